// ===== hw/rtl/md5sh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package md5sh_pkg;

  // Initial chaining words A, B, C, D; index 0 is A.
  localparam logic [3:0][31:0] CHAIN_INIT = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] PAD_MARKER   = 8'h80;
  localparam int         BLOCK_WORDS  = 16;
  localparam int         WORD_AW      = $clog2(BLOCK_WORDS);
  localparam int         COUNT_W      = 61;
  localparam logic [3:0] LEN_LO_WORD  = 4'd14;
  localparam logic [3:0] LEN_HI_WORD  = 4'd15;
  localparam logic [1:0] WORD_LAST    = 2'd3;
  localparam logic [1:0] LANE_LAST    = 2'd3;

  // Round group codes, taken from bits 5:4 of the round number.
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;
  localparam logic [1:0] GRP_I = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } work_t;

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = rnd[3:0];
    case (rnd[5:4])
      GRP_F:   idx = lo;
      GRP_G:   idx = 4'(lo * 4'd5 + 4'd1);
      GRP_H:   idx = 4'(lo * 4'd3 + 4'd5);
      GRP_I:   idx = 4'(lo * 4'd7);
      default: idx = lo;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      4'd15:   s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] sine_const(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'hd76aa478;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/md5sh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module md5sh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/md5sh_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One MD5 step: round function, sine constant, rotate, rotate the words.
module md5sh_round (
  input  wire md5sh_pkg::work_t  work_in,
  input  wire logic [31:0]       msg_word,
  input  wire logic [5:0]        rnd,
  output md5sh_pkg::work_t       work_out
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] shl;

  always_comb begin
    case (rnd[5:4])
      md5sh_pkg::GRP_F: f = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
      md5sh_pkg::GRP_G: f = (work_in.d & work_in.b) | (~work_in.d & work_in.c);
      md5sh_pkg::GRP_H: f = work_in.b ^ work_in.c ^ work_in.d;
      md5sh_pkg::GRP_I: f = work_in.c ^ (work_in.b | ~work_in.d);
      default:          f = work_in.b ^ work_in.c ^ work_in.d;
    endcase
  end

  assign sum = work_in.a + f + msg_word + md5sh_pkg::sine_const(rnd);
  assign s   = md5sh_pkg::rot_amount(rnd);
  assign shl = {sum, sum} << s;

  assign work_out.a = work_in.d;
  assign work_out.d = work_in.c;
  assign work_out.c = work_in.b;
  assign work_out.b = work_in.b + shl[63:32];

endmodule

`default_nettype wire

// ===== hw/rtl/md5_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// MD5 stream hasher.
// Input channel (in_valid / in_stall / in_data): one transaction per message
// byte, with byte_present and end_of_message flags. A transaction with
// neither flag does nothing. end_of_message finishes the message after the
// byte it may carry.
// Output channel (out_valid / out_stall / out_data): four transactions per
// message, the digest words A, B, C, D with word_index 0..3, last_word on
// the fourth.
// Timing: bytes are taken one per cycle while in_stall is low. The 64th byte
// of a block starts a compression (load, 64 rounds through one shared round
// unit, chain update), during which in_stall is high. End of message writes
// the marker word, then the rest of the padding block, and compresses it; a
// second padding block is written and compressed when the length does not
// fit (56 bytes or more in the last block). The digest words then follow one
// per cycle while the receiver does not stall.
// The message block sits in a 16 x 32 bit RAM whose read port feeds the round
// unit one message word per cycle.
// Reset (rst_n low, synchronous) loads the initial chaining words, clears the
// byte count and returns to idle. While the receiver stalls, the current
// digest word is held and in_stall stays high until all four are taken.
module md5_stream_hasher (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire md5sh_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output md5sh_pkg::out_item_t      out_data
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_PAD_FIRST = 7'b0000010,
    S_PAD_FILL  = 7'b0000100,
    S_SETUP     = 7'b0001000,
    S_ROUND     = 7'b0010000,
    S_UPDATE    = 7'b0100000,
    S_EMIT      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [md5sh_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [23:0]                   acc_r, acc_nxt;
  logic [3:0][31:0]              chain_r, chain_nxt;
  md5sh_pkg::work_t              work_r, work_nxt;
  logic [5:0]                    rnd_r, rnd_nxt;
  logic [3:0]                    ptr_r, ptr_nxt;
  logic [1:0]                    oidx_r, oidx_nxt;
  logic                          pend_end_r, pend_end_nxt;
  logic                          fin_r, fin_nxt;
  logic                          two_r, two_nxt;
  logic                          second_r, second_nxt;

  logic                          in_acc;
  logic                          out_acc;
  logic [1:0]                    lane;
  logic [63:0]                   bit_len;
  logic [31:0]                   pad_word;
  logic                          len_ok;
  logic                          ram_we;
  logic [md5sh_pkg::WORD_AW-1:0] ram_waddr;
  logic [31:0]                   ram_wdata;
  logic [md5sh_pkg::WORD_AW-1:0] ram_raddr;
  logic [31:0]                   ram_rdata;
  md5sh_pkg::work_t              work_step;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign lane    = count_r[1:0];
  assign bit_len = {count_r, 3'b000};
  // Length words go in only on the block that carries them.
  assign len_ok  = !two_r || second_r;

  // Marker word: keep the bytes already gathered, add the marker, zero the rest.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < lane) begin
        pad_word[8*k +: 8] = acc_r[8*k +: 8];
      end else if (2'(k) == lane) begin
        pad_word[8*k +: 8] = md5sh_pkg::PAD_MARKER;
      end else begin
        pad_word[8*k +: 8] = 8'h00;
      end
    end
    pad_word[31:24] = (lane == md5sh_pkg::LANE_LAST) ? md5sh_pkg::PAD_MARKER : 8'h00;
  end

  md5sh_ram #(
    .WIDTH(32),
    .DEPTH(md5sh_pkg::BLOCK_WORDS)
  ) u_block_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Prefetch the message word of the next round.
  assign ram_raddr = (state_r == S_ROUND) ? md5sh_pkg::msg_index(6'(rnd_r + 6'd1))
                                          : md5sh_pkg::msg_index(6'd0);

  md5sh_round u_round (
    .work_in (work_r),
    .msg_word(ram_rdata),
    .rnd     (rnd_r),
    .work_out(work_step)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    acc_nxt      = acc_r;
    chain_nxt    = chain_r;
    work_nxt     = work_r;
    rnd_nxt      = rnd_r;
    ptr_nxt      = ptr_r;
    oidx_nxt     = oidx_r;
    pend_end_nxt = pend_end_r;
    fin_nxt      = fin_r;
    two_nxt      = two_r;
    second_nxt   = second_r;
    ram_we       = 1'b0;
    ram_waddr    = count_r[5:2];
    ram_wdata    = {in_data.data_byte, acc_r};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.byte_present) begin
            count_nxt = count_r + 1'b1;
            if (lane == md5sh_pkg::LANE_LAST) begin
              ram_we = 1'b1;
            end else begin
              acc_nxt[8*lane +: 8] = in_data.data_byte;
            end
          end
          if (in_data.byte_present && count_r[5:0] == 6'h3F) begin
            // Block full: compress first, finish afterwards if asked.
            pend_end_nxt = in_data.end_of_message;
            fin_nxt      = 1'b0;
            state_nxt    = S_SETUP;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD_FIRST;
          end
        end
      end

      S_PAD_FIRST: begin
        ram_we       = 1'b1;
        ram_waddr    = count_r[5:2];
        ram_wdata    = pad_word;
        fin_nxt      = 1'b1;
        pend_end_nxt = 1'b0;
        second_nxt   = 1'b0;
        two_nxt      = count_r[5:0] inside {[6'd56:6'd63]};
        ptr_nxt      = 4'(count_r[5:2] + 4'd1);
        state_nxt    = (count_r[5:2] == md5sh_pkg::LEN_HI_WORD) ? S_SETUP : S_PAD_FILL;
      end

      S_PAD_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        if (len_ok && ptr_r == md5sh_pkg::LEN_LO_WORD) begin
          ram_wdata = bit_len[31:0];
        end else if (len_ok && ptr_r == md5sh_pkg::LEN_HI_WORD) begin
          ram_wdata = bit_len[63:32];
        end else begin
          ram_wdata = 32'h0;
        end
        ptr_nxt = 4'(ptr_r + 4'd1);
        if (ptr_r == md5sh_pkg::LEN_HI_WORD) begin
          state_nxt = S_SETUP;
        end
      end

      S_SETUP: begin
        work_nxt.a = chain_r[0];
        work_nxt.b = chain_r[1];
        work_nxt.c = chain_r[2];
        work_nxt.d = chain_r[3];
        rnd_nxt    = 6'd0;
        state_nxt  = S_ROUND;
      end

      S_ROUND: begin
        work_nxt = work_step;
        rnd_nxt  = 6'(rnd_r + 6'd1);
        if (rnd_r == 6'h3F) begin
          state_nxt = S_UPDATE;
        end
      end

      S_UPDATE: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        if (fin_r) begin
          if (two_r && !second_r) begin
            second_nxt = 1'b1;
            ptr_nxt    = 4'd0;
            state_nxt  = S_PAD_FILL;
          end else begin
            oidx_nxt  = 2'd0;
            state_nxt = S_EMIT;
          end
        end else if (pend_end_r) begin
          state_nxt = S_PAD_FIRST;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_acc) begin
          oidx_nxt = 2'(oidx_r + 2'd1);
          if (oidx_r == md5sh_pkg::WORD_LAST) begin
            // Drop back to the initial chain for the next message.
            chain_nxt = md5sh_pkg::CHAIN_INIT;
            count_nxt = '0;
            fin_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid            = (state_r == S_EMIT);
  assign out_data.digest_word = chain_r[oidx_r];
  assign out_data.word_index  = oidx_r;
  assign out_data.last_word   = (oidx_r == md5sh_pkg::WORD_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      chain_r    <= md5sh_pkg::CHAIN_INIT;
      oidx_r     <= 2'd0;
      pend_end_r <= 1'b0;
      fin_r      <= 1'b0;
      two_r      <= 1'b0;
      second_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      chain_r    <= chain_nxt;
      oidx_r     <= oidx_nxt;
      pend_end_r <= pend_end_nxt;
      fin_r      <= fin_nxt;
      two_r      <= two_nxt;
      second_r   <= second_nxt;
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    work_r <= work_nxt;
    rnd_r  <= rnd_nxt;
    ptr_r  <= ptr_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_md5_stream_hasher.sv =====
`timescale 1ns / 1ps

// Testbench for md5_stream_hasher.
// Drive byte transactions on the input channel, predict every digest with
// an in-bench MD5 model and compare each digest word on the output channel.
module tb_md5_stream_hasher;

  // Random stimulus stops after this many transactions and this many
  // finished messages, whichever comes later.
  localparam int RAND_ITEMS     = 260;
  localparam int MIN_MESSAGES   = 8;
  // Receiver hold-off: start once this many digest words are in, then
  // keep stalling for this many cycles so the block backs up.
  localparam int HOLD_AFTER     = 32;
  localparam int HOLD_CYCLES    = 500;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  // Window of random transactions sent with no idling on either side.
  localparam int STEADY_FROM    = 60;
  localparam int STEADY_TO      = 160;
  // Byte offset of the bit length in the final padded block.
  localparam int LEN_OFFSET     = 56;
  // Message lengths that sit on the padding boundaries.
  localparam int PAD_EDGES [6]  = '{54, 55, 56, 63, 64, 65};

  // Known digests, word 0 first, each word little-endian.
  localparam logic [127:0] EMPTY_DIGEST = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;
  localparam logic [127:0] ABC_DIGEST   = 128'h98500190_b04fd23c_7d3f96d6_727fe128;
  localparam logic [127:0] NO_DIGEST    = '0;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int SHIFT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         golden;
    logic [127:0] digest;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  md5sh_pkg::in_item_t  in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  md5sh_pkg::out_item_t out_data;

  // Shadow hashing state: chaining words, block buffer, byte count.
  logic [31:0] chain_state [4];
  logic [7:0]  block_bytes [64];
  logic [60:0] msg_len;

  md5sh_pkg::out_item_t digest_q [$];
  md5sh_pkg::out_item_t want_word;
  int        mismatches   = 0;
  int        words_taken  = 0;
  int        hold_left    = 0;
  bit        hold_done    = 1'b0;
  logic      steady       = 1'b0;
  int        quiet_cycles = 0;

  dir_row_t  dir_rows [17];

  md5_stream_hasher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void restart_chain();
    for (int w = 0; w < 4; w++) chain_state[w] = md5sh_pkg::CHAIN_INIT[w];
    msg_len = '0;
  endfunction

  // Run the 64 rounds over the current block and fold them into the chain.
  function automatic void md5_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int w = 0; w < 16; w++)
      m[w] = {block_bytes[4*w+3], block_bytes[4*w+2], block_bytes[4*w+1], block_bytes[4*w]};
    a = chain_state[0];
    b = chain_state[1];
    c = chain_state[2];
    d = chain_state[3];
    for (int i = 0; i < 64; i++) begin
      case (2'(i >> 4))
        md5sh_pkg::GRP_F: begin f = (b & c) | (~b & d); g = i; end
        md5sh_pkg::GRP_G: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        md5sh_pkg::GRP_H: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        md5sh_pkg::GRP_I: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
        default:          begin f = b ^ c ^ d; g = i % 16; end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl32(a + f + m[g] + SINE_K[i], SHIFT_AMT[(i >> 4) * 4 + i % 4]);
      a = t;
    end
    chain_state[0] += a;
    chain_state[1] += b;
    chain_state[2] += c;
    chain_state[3] += d;
  endfunction

  // Absorb one accepted transaction; on end of message pad, finish the
  // digest and hand it back.
  function automatic void absorb_item(input md5sh_pkg::in_item_t it, output logic done,
                                      output logic [3:0][31:0] dig);
    logic [5:0]  fill;
    logic [63:0] bit_len;
    done = 1'b0;
    dig  = '0;
    if (it.byte_present) begin
      block_bytes[msg_len[5:0]] = it.data_byte;
      msg_len = msg_len + 61'd1;
      if (msg_len[5:0] == 6'd0) md5_compress();
    end
    if (it.end_of_message) begin
      fill    = msg_len[5:0];
      bit_len = {msg_len, 3'b000};
      block_bytes[fill] = md5sh_pkg::PAD_MARKER;
      for (int k = fill + 1; k < 64; k++) block_bytes[k] = 8'h00;
      // No room left for the length: spill it into a second block.
      if (fill >= LEN_OFFSET) begin
        md5_compress();
        for (int k = 0; k < LEN_OFFSET; k++) block_bytes[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) block_bytes[LEN_OFFSET + k] = bit_len[8*k +: 8];
      md5_compress();
      for (int w = 0; w < 4; w++) dig[w] = chain_state[w];
      restart_chain();
      done = 1'b1;
    end
  endfunction

  // Present one transaction, hold it until it is taken, then predict.
  // A golden digest, where given, replaces the predicted words.
  task automatic offer(input md5sh_pkg::in_item_t it, input logic golden,
                       input logic [127:0] gold);
    logic                 done;
    logic [3:0][31:0]     dig;
    md5sh_pkg::out_item_t word;
    if (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    absorb_item(it, done, dig);
    if (done) begin
      for (int w = 0; w < 4; w++) begin
        word.digest_word = golden ? gold[127 - 32*w -: 32] : dig[w];
        word.word_index  = 2'(w);
        word.last_word   = (2'(w) == md5sh_pkg::WORD_LAST);
        digest_q.push_back(word);
      end
    end
  endtask

  // Receiver: check each accepted digest word, then pick the next stall.
  // Out_stall and the DUT outputs read here are the values before this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: digest word %h index %0d with nothing expected",
                 $time, out_data.digest_word, out_data.word_index);
        mismatches++;
      end else begin
        want_word = digest_q.pop_front();
        if (out_data.digest_word !== want_word.digest_word ||
            out_data.word_index  !== want_word.word_index  ||
            out_data.last_word   !== want_word.last_word) begin
          $display("%0t: digest mismatch: expected %h/%0d/%0d, got %h/%0d/%0d", $time,
                   want_word.digest_word, want_word.word_index, want_word.last_word,
                   out_data.digest_word, out_data.word_index, out_data.last_word);
          mismatches++;
        end
      end
      words_taken++;
    end
    // Hold off once for a long stretch so the block fills and stalls its input.
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && words_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 33);
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    md5sh_pkg::in_item_t it;
    int       items_sent;
    int       msgs_done;
    int       msg_bytes;
    bit       joined_end;

    // Directed rows: ignored transactions, the empty message, byte and end
    // together, extreme byte values, an end with an unused byte attached,
    // and a fresh empty message to show the chain restarts.
    dir_rows = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      '{8'ha5, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
      '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
      '{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h7f, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'hff, 1'b0, 1'b1, 1'b0, NO_DIGEST},
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
    };
    items_sent = 0;
    msgs_done  = 0;
    restart_chain();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      it.data_byte      = dir_rows[r].data;
      it.byte_present   = dir_rows[r].present;
      it.end_of_message = dir_rows[r].eom;
      offer(it, dir_rows[r].golden, dir_rows[r].digest);
    end

    // Random messages: many short ones, a good share on the padding
    // boundaries and a few of two blocks or more, with stray empty
    // transactions mixed in.
    while (items_sent < RAND_ITEMS || msgs_done < MIN_MESSAGES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: msg_bytes = $urandom_range(0, 12);
        4, 5, 6:    msg_bytes = PAD_EDGES[$urandom_range(0, 5)];
        7, 8:       msg_bytes = $urandom_range(13, 70);
        default:    msg_bytes = $urandom_range(118, 128);
      endcase
      joined_end = (msg_bytes != 0) && $urandom_range(0, 1);
      // A stretch of messages with no idling on either side.
      steady <= (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
      for (int n = 0; n < msg_bytes; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          it.data_byte      = 8'($urandom);
          it.byte_present   = 1'b0;
          it.end_of_message = 1'b0;
          offer(it, 1'b0, NO_DIGEST);
          items_sent++;
        end
        it.data_byte      = 8'($urandom);
        it.byte_present   = 1'b1;
        it.end_of_message = joined_end && (n == msg_bytes - 1);
        offer(it, 1'b0, NO_DIGEST);
        items_sent++;
      end
      if (!joined_end) begin
        it.data_byte      = 8'($urandom);
        it.byte_present   = 1'b0;
        it.end_of_message = 1'b1;
        offer(it, 1'b0, NO_DIGEST);
        items_sent++;
      end
      msgs_done++;
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected word, then watch for strays.
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
